@@ hdl/tpid_pkg.sv @@
// ----------------------------------------------------------------------------
// tpid_pkg
// Shared widths, register codes and types of the three-axis pid unit
// ----------------------------------------------------------------------------
package tpid_pkg;

  localparam int MaxWindow = 64;
  localparam int PtrW      = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;

  localparam int SampleW   = 16;
  localparam int GainW     = 16;
  localparam int FiltW     = 16;
  localparam int LenW      = 7;
  localparam int AdjW      = 24;
  localparam int DerivW    = 18;
  localparam int SumW      = SampleW + 1 + PtrW;
  localparam int LenCmpW   = (LenW > PtrW + 1) ? LenW : PtrW + 1;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 16;
  localparam int RowW      = 3 * SampleW;
  localparam int NumAxes   = 3;

  localparam logic signed [GainW-1:0] GainPropRst  = 16'sd256;
  localparam logic signed [GainW-1:0] GainIntegRst = 16'sd0;
  localparam logic signed [GainW-1:0] GainDerivRst = 16'sd0;
  localparam logic        [FiltW-1:0] FiltRst      = 16'hFFFF;
  localparam logic        [LenW-1:0]  WinLenRst    = 7'd16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN_PROP  = 3'd0,
    CFG_GAIN_INTEG = 3'd1,
    CFG_GAIN_DERIV = 3'd2,
    CFG_FILT       = 3'd3,
    CFG_WIN_LEN    = 3'd4
  } cfg_idx_e;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [AdjW-1:0]    adj_t;

  // per-step strobes from the sequencer and the window clear, to the axis lanes
  typedef struct packed {
    logic step1;
    logic step2;
    logic clr_win;
  } lane_ctrl_t;

endpackage

@@ hdl/tpid_if.sv @@
// ----------------------------------------------------------------------------
// tpid channel interfaces
// Tilt input, correction output and register write channels
// ----------------------------------------------------------------------------
interface tpid_tilt_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [tpid_pkg::SampleW-1:0]   tilt_roll;
  logic signed [tpid_pkg::SampleW-1:0]   tilt_pitch;
  logic signed [tpid_pkg::SampleW-1:0]   tilt_yaw;

  modport source (output valid, tilt_roll, tilt_pitch, tilt_yaw, input ready);
  modport sink   (input valid, tilt_roll, tilt_pitch, tilt_yaw, output ready);
endinterface

interface tpid_adj_if;
  logic                                valid;
  logic                                ready;
  logic signed [tpid_pkg::AdjW-1:0]    adj_roll;
  logic signed [tpid_pkg::AdjW-1:0]    adj_pitch;
  logic signed [tpid_pkg::AdjW-1:0]    adj_yaw;

  modport source (output valid, adj_roll, adj_pitch, adj_yaw, input ready);
  modport sink   (input valid, adj_roll, adj_pitch, adj_yaw, output ready);
endinterface

interface tpid_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tpid_pkg::CfgIdxW-1:0]      index;
  logic [tpid_pkg::CfgDataW-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/three_axis_pid_windowed_integral_unit.sv @@
// ----------------------------------------------------------------------------
// three_axis_pid_windowed_integral_unit
// Three-axis pid with a sliding-window integral held in a sample ring
// ----------------------------------------------------------------------------
//  port     dir   modport  moves
//  tilt_i   in    sink     roll, pitch, yaw error sample
//  adj_o    out   source   roll, pitch, yaw correction
//  cfg_i    in    sink     register write (index, data), always ready
//
//  the steps of one sample: accept and ring read, sum update and write
//  back with the first products, derivative filter with the second
//  products, final add into the output register. the sequencer takes one
//  sample at a time, with a single read-modify-write of its ring slot.
//  a new sample is taken while a result still waits on adj_o; step four
//  holds until the output register is free. no clearing pass after reset:
//  per-slot valid bits clear at once.
// ----------------------------------------------------------------------------
module three_axis_pid_windowed_integral_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  tpid_tilt_if.sink  tilt_i,
  tpid_adj_if.source adj_o,
  tpid_cfg_if.sink   cfg_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL1 = 2'd1;
  localparam logic [1:0] S_MUL2 = 2'd2;
  localparam logic [1:0] S_SUM  = 2'd3;

  logic [1:0] state_q, state_d;

  logic signed [tpid_pkg::GainW-1:0] gain_prop_q, gain_integ_q, gain_deriv_q;
  logic        [tpid_pkg::FiltW-1:0] filt_q;
  logic        [tpid_pkg::LenW-1:0]  win_len_q;

  logic [tpid_pkg::PtrW-1:0]         ptr_q, ptr_d;
  logic [tpid_pkg::MaxWindow-1:0]    vld_q;
  tpid_pkg::sample_t                 tilt_q [tpid_pkg::NumAxes];
  tpid_pkg::sample_t                 old_smp [tpid_pkg::NumAxes];
  tpid_pkg::adj_t                    lane_adj [tpid_pkg::NumAxes];
  tpid_pkg::adj_t                    adj_q [tpid_pkg::NumAxes];
  logic                              out_vld_q;

  logic                              tilt_fire, cfg_fire, win_clr, out_load;
  logic [tpid_pkg::RowW-1:0]         rd_row;
  logic [tpid_pkg::LenCmpW-1:0]      eff_len, len_ext, slot_inc;
  tpid_pkg::lane_ctrl_t              lane_ctrl;

  assign tilt_i.ready = (state_q == S_IDLE);
  assign tilt_fire    = tilt_i.valid && tilt_i.ready;
  assign cfg_i.ready  = 1'b1;
  assign cfg_fire     = cfg_i.valid;
  assign win_clr      = cfg_fire &&
                        (tpid_pkg::cfg_idx_e'(cfg_i.index) == tpid_pkg::CFG_WIN_LEN);
  assign out_load     = (state_q == S_SUM) && (!out_vld_q || adj_o.ready);

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_prop_q  <= tpid_pkg::GainPropRst;
      gain_integ_q <= tpid_pkg::GainIntegRst;
      gain_deriv_q <= tpid_pkg::GainDerivRst;
      filt_q       <= tpid_pkg::FiltRst;
      win_len_q    <= tpid_pkg::WinLenRst;
    end else if (cfg_fire) begin
      unique case (tpid_pkg::cfg_idx_e'(cfg_i.index))
        tpid_pkg::CFG_GAIN_PROP:  gain_prop_q  <= $signed(cfg_i.data);
        tpid_pkg::CFG_GAIN_INTEG: gain_integ_q <= $signed(cfg_i.data);
        tpid_pkg::CFG_GAIN_DERIV: gain_deriv_q <= $signed(cfg_i.data);
        tpid_pkg::CFG_FILT:       filt_q       <= cfg_i.data;
        tpid_pkg::CFG_WIN_LEN:    win_len_q    <= cfg_i.data[tpid_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  // effective window length and next ring slot
  assign len_ext  = tpid_pkg::LenCmpW'(win_len_q);
  assign slot_inc = tpid_pkg::LenCmpW'(ptr_q) + tpid_pkg::LenCmpW'(1);

  always_comb begin
    if (win_len_q == '0) begin
      eff_len = tpid_pkg::LenCmpW'(1);
    end else if (len_ext > tpid_pkg::LenCmpW'(tpid_pkg::MaxWindow)) begin
      eff_len = tpid_pkg::LenCmpW'(tpid_pkg::MaxWindow);
    end else begin
      eff_len = len_ext;
    end
    if (slot_inc >= eff_len) begin
      ptr_d = '0;
    end else begin
      ptr_d = slot_inc[tpid_pkg::PtrW-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (tilt_fire) state_d = S_MUL1;
      S_MUL1:  state_d = S_MUL2;
      S_MUL2:  state_d = S_SUM;
      S_SUM:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ring pointer and slot valid bits; a slot never written reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      vld_q <= '0;
    end else if (win_clr) begin
      ptr_q <= '0;
      vld_q <= '0;
    end else if (state_q == S_MUL1) begin
      ptr_q        <= ptr_d;
      vld_q[ptr_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tilt_fire) begin
      tilt_q[0] <= tilt_i.tilt_roll;
      tilt_q[1] <= tilt_i.tilt_pitch;
      tilt_q[2] <= tilt_i.tilt_yaw;
    end
  end

  tpid_win_ram u_win_ram (
    .clk_i     (clk_i),
    .wr_en_i   (state_q == S_MUL1),
    .wr_addr_i (ptr_q),
    .wr_data_i ({tilt_q[2], tilt_q[1], tilt_q[0]}),
    .rd_en_i   (tilt_fire),
    .rd_addr_i (ptr_q),
    .rd_data_o (rd_row)
  );

  always_comb begin
    for (int a = 0; a < tpid_pkg::NumAxes; a++) begin
      old_smp[a] = vld_q[ptr_q] ? $signed(rd_row[a*tpid_pkg::SampleW +: tpid_pkg::SampleW])
                                : '0;
    end
  end

  assign lane_ctrl.step1   = (state_q == S_MUL1);
  assign lane_ctrl.step2   = (state_q == S_MUL2);
  assign lane_ctrl.clr_win = win_clr;

  for (genvar g = 0; g < tpid_pkg::NumAxes; g++) begin : g_lane
    tpid_axis_lane u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (lane_ctrl),
      .tilt_i       (tilt_q[g]),
      .old_i        (old_smp[g]),
      .gain_prop_i  (gain_prop_q),
      .gain_integ_i (gain_integ_q),
      .gain_deriv_i (gain_deriv_q),
      .filt_i       (filt_q),
      .adj_o        (lane_adj[g])
    );
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (adj_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      for (int a = 0; a < tpid_pkg::NumAxes; a++) begin
        adj_q[a] <= lane_adj[a];
      end
    end
  end

  assign adj_o.valid     = out_vld_q;
  assign adj_o.adj_roll  = adj_q[0];
  assign adj_o.adj_pitch = adj_q[1];
  assign adj_o.adj_yaw   = adj_q[2];

endmodule

@@ hdl/tpid_win_ram.sv @@
// ----------------------------------------------------------------------------
// tpid_win_ram
// Sample window store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module tpid_win_ram (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [tpid_pkg::PtrW-1:0]     wr_addr_i,
  input  logic [tpid_pkg::RowW-1:0]     wr_data_i,
  input  logic                          rd_en_i,
  input  logic [tpid_pkg::PtrW-1:0]     rd_addr_i,
  output logic [tpid_pkg::RowW-1:0]     rd_data_o
);

  logic [tpid_pkg::RowW-1:0] mem_q [tpid_pkg::MaxWindow];
  logic [tpid_pkg::RowW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hdl/tpid_axis_lane.sv @@
// ----------------------------------------------------------------------------
// tpid_axis_lane
// One axis: window sum, filtered derivative and the gain products
// ----------------------------------------------------------------------------
module tpid_axis_lane (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  tpid_pkg::lane_ctrl_t               ctrl_i,
  input  tpid_pkg::sample_t                  tilt_i,
  input  tpid_pkg::sample_t                  old_i,
  input  logic signed [tpid_pkg::GainW-1:0]  gain_prop_i,
  input  logic signed [tpid_pkg::GainW-1:0]  gain_integ_i,
  input  logic signed [tpid_pkg::GainW-1:0]  gain_deriv_i,
  input  logic        [tpid_pkg::FiltW-1:0]  filt_i,
  output tpid_pkg::adj_t                     adj_o
);

  localparam int DiffW  = tpid_pkg::SampleW + 1;
  localparam int DeltaW = tpid_pkg::DerivW + 1;
  localparam int KProdW = tpid_pkg::FiltW + 1 + DeltaW;
  localparam int KRndW  = KProdW + 1;
  localparam int PPropW = tpid_pkg::GainW + tpid_pkg::SampleW;
  localparam int PIntW  = tpid_pkg::GainW + tpid_pkg::SumW;
  localparam int PDerW  = tpid_pkg::GainW + tpid_pkg::DerivW;
  localparam int AccW   = PIntW + 2;

  logic signed [tpid_pkg::SumW-1:0]   sum_q, sum_d;
  tpid_pkg::sample_t                  prev_q;
  logic signed [tpid_pkg::DerivW-1:0] fd_q, fd_d;
  logic signed [KProdW-1:0]           kprod_q, kprod_d;
  logic signed [PPropW-1:0]           pprop_q, pprop_d;
  logic signed [PIntW-1:0]            pint_q, pint_d;
  logic signed [PDerW-1:0]            pder_q, pder_d;

  logic signed [DiffW-1:0]            diff;
  logic signed [DeltaW-1:0]           delta;
  logic signed [KRndW-1:0]            krnd;
  logic signed [AccW-1:0]             acc;
  logic signed [AccW-1:0]             acc_sh;

  // step one: window sum, derivative error product, proportional product
  assign sum_d   = sum_q + tpid_pkg::SumW'(tilt_i) - tpid_pkg::SumW'(old_i);
  assign diff    = DiffW'(tilt_i) - DiffW'(prev_q);
  assign delta   = DeltaW'(diff) - DeltaW'(fd_q);
  assign kprod_d = $signed({1'b0, filt_i}) * delta;
  assign pprop_d = gain_prop_i * tilt_i;

  // step two: round the filter step, then integral and derivative products
  assign krnd    = KRndW'(kprod_q) + KRndW'(32768);
  assign fd_d    = fd_q + tpid_pkg::DerivW'(krnd >>> 16);
  assign pint_d  = gain_integ_i * sum_q;
  assign pder_d  = gain_deriv_i * fd_d;

  // final add, round half up, clamp
  assign acc    = AccW'(pprop_q) + AccW'(pint_q) + AccW'(pder_q) + AccW'(128);
  assign acc_sh = acc >>> 8;

  always_comb begin
    if (acc_sh > AccW'(8388607)) begin
      adj_o = 24'sh7FFFFF;
    end else if (acc_sh < -AccW'(8388608)) begin
      adj_o = 24'sh800000;
    end else begin
      adj_o = tpid_pkg::AdjW'(acc_sh);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      prev_q <= '0;
      fd_q   <= '0;
    end else begin
      if (ctrl_i.clr_win) begin
        sum_q <= '0;
      end else if (ctrl_i.step1) begin
        sum_q <= sum_d;
      end
      if (ctrl_i.step1) begin
        prev_q <= tilt_i;
      end
      if (ctrl_i.step2) begin
        fd_q <= fd_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.step1) begin
      kprod_q <= kprod_d;
      pprop_q <= pprop_d;
    end
    if (ctrl_i.step2) begin
      pint_q <= pint_d;
      pder_q <= pder_d;
    end
  end

endmodule

@@ hdl/tpid_checker.sv @@
// ----------------------------------------------------------------------------
// tpid_checker
// Port-level timing checks of the three-axis pid unit
// ----------------------------------------------------------------------------
module tpid_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [tpid_pkg::AdjW-1:0]    out_roll_i,
  input logic [tpid_pkg::AdjW-1:0]    out_pitch_i,
  input logic [tpid_pkg::AdjW-1:0]    out_yaw_i
);

  // one sample in flight: no transfer right after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("tilt accepted while previous sample still in work");

  // with the output free, the result shows once the unit has passed MUL1, MUL2 and SUM
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && !out_valid_i) |-> ##3 !out_valid_i ##1 out_valid_i)
    else $error("result latency off");

  // a new result frees the input at the same time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> in_ready_i)
    else $error("input not ready when result appeared");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_roll_i) && $stable(out_pitch_i) &&
       $stable(out_yaw_i)))
    else $error("stalled result changed");

endmodule

bind three_axis_pid_windowed_integral_unit tpid_checker u_tpid_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (tilt_i.valid),
  .in_ready_i  (tilt_i.ready),
  .out_valid_i (adj_o.valid),
  .out_ready_i (adj_o.ready),
  .out_roll_i  (adj_o.adj_roll),
  .out_pitch_i (adj_o.adj_pitch),
  .out_yaw_i   (adj_o.adj_yaw)
);

@@ bench/three_axis_pid_windowed_integral_unit_tb.sv @@
// ----------------------------------------------------------------------------
// three_axis_pid_windowed_integral_unit_tb
// Self-checking bench: tilt samples go in, and every correction that comes
// out is compared with a bit-exact prediction of the windowed pid.
// ----------------------------------------------------------------------------
module three_axis_pid_windowed_integral_unit_tb;

  localparam int LimitCycles = 400000;
  localparam int DrainCycles = 8;

  localparam tpid_pkg::sample_t SampleMax = 16'sh7FFF;
  localparam tpid_pkg::sample_t SampleMin = 16'sh8000;

  typedef struct packed {
    tpid_pkg::adj_t roll;
    tpid_pkg::adj_t pitch;
    tpid_pkg::adj_t yaw;
  } adj_set_t;

  class pid_scoreboard;
    int       errors;
    adj_set_t pending_adj[$];

    int          gain_p, gain_i, gain_d;
    int          filt_k;
    int unsigned win_len;

    tpid_pkg::sample_t ring[tpid_pkg::MaxWindow][tpid_pkg::NumAxes];
    int unsigned       ring_ptr;
    int                win_sum[tpid_pkg::NumAxes];
    int                prev_tilt[tpid_pkg::NumAxes];
    int                filt_deriv[tpid_pkg::NumAxes];

    function new();
      errors  = 0;
      gain_p  = 256;
      gain_i  = 0;
      gain_d  = 0;
      filt_k  = 65535;
      win_len = 16;
      clear_window();
      for (int a = 0; a < tpid_pkg::NumAxes; a++) begin
        prev_tilt[a]  = 0;
        filt_deriv[a] = 0;
      end
    endfunction

    function void clear_window();
      for (int s = 0; s < tpid_pkg::MaxWindow; s++) begin
        for (int a = 0; a < tpid_pkg::NumAxes; a++) ring[s][a] = '0;
      end
      for (int a = 0; a < tpid_pkg::NumAxes; a++) win_sum[a] = 0;
      ring_ptr = 0;
    endfunction

    function int pending();
      return pending_adj.size();
    endfunction

    function void write_reg(logic [tpid_pkg::CfgIdxW-1:0] idx,
                            logic [tpid_pkg::CfgDataW-1:0] data);
      case (idx)
        tpid_pkg::CFG_GAIN_PROP:  gain_p = $signed(data);
        tpid_pkg::CFG_GAIN_INTEG: gain_i = $signed(data);
        tpid_pkg::CFG_GAIN_DERIV: gain_d = $signed(data);
        tpid_pkg::CFG_FILT:       filt_k = data;
        tpid_pkg::CFG_WIN_LEN: begin
          win_len = data[tpid_pkg::LenW-1:0];
          clear_window();
        end
        default: ;
      endcase
    endfunction

    function tpid_pkg::adj_t correct_axis(int a, int unsigned slot,
                                          tpid_pkg::sample_t tilt);
      longint diff, delta, deriv, acc;
      win_sum[a]    = win_sum[a] + tilt - ring[slot][a];
      ring[slot][a] = tilt;
      diff  = longint'(tilt) - prev_tilt[a];
      delta = diff - filt_deriv[a];
      deriv = filt_deriv[a] + ((longint'(filt_k) * delta + 32768) >>> 16);
      filt_deriv[a] = int'(deriv);
      prev_tilt[a]  = tilt;
      acc = longint'(gain_p) * tilt + longint'(gain_i) * win_sum[a]
          + longint'(gain_d) * deriv;
      acc = (acc + 128) >>> 8;
      if (acc > 8388607) acc = 8388607;
      if (acc < -8388608) acc = -8388608;
      return tpid_pkg::adj_t'(acc);
    endfunction

    function void note_tilt(tpid_pkg::sample_t roll, tpid_pkg::sample_t pitch,
                            tpid_pkg::sample_t yaw);
      int unsigned eff_len, slot;
      adj_set_t    want;
      eff_len = (win_len == 0) ? 1 :
                (win_len > tpid_pkg::MaxWindow) ? tpid_pkg::MaxWindow : win_len;
      slot    = (ring_ptr >= tpid_pkg::MaxWindow) ? 0 : ring_ptr;
      want.roll  = correct_axis(0, slot, roll);
      want.pitch = correct_axis(1, slot, pitch);
      want.yaw   = correct_axis(2, slot, yaw);
      ring_ptr   = (slot + 1 >= eff_len) ? 0 : slot + 1;
      pending_adj.push_back(want);
    endfunction

    function void check_field(string name, tpid_pkg::adj_t want, tpid_pkg::adj_t got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_adj(tpid_pkg::adj_t roll, tpid_pkg::adj_t pitch,
                            tpid_pkg::adj_t yaw);
      adj_set_t want;
      if (pending_adj.size() == 0) begin
        errors++;
        $display("%0t: unexpected correction, expected none, actual %0d %0d %0d",
                 $time, roll, pitch, yaw);
      end else begin
        want = pending_adj.pop_front();
        check_field("adj_roll", want.roll, roll);
        check_field("adj_pitch", want.pitch, pitch);
        check_field("adj_yaw", want.yaw, yaw);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  tpid_tilt_if tilt_ch ();
  tpid_adj_if  adj_ch ();
  tpid_cfg_if  cfg_ch ();

  three_axis_pid_windowed_integral_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tilt_i (tilt_ch),
    .adj_o  (adj_ch),
    .cfg_i  (cfg_ch)
  );

  pid_scoreboard board = new();

  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int cycles        = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    while (cycles < LimitCycles) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  // result side: check each transfer, then pick ready for the next edge
  initial begin
    adj_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (adj_ch.valid && adj_ch.ready)
        board.check_adj(adj_ch.adj_roll, adj_ch.adj_pitch, adj_ch.adj_yaw);
      adj_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // valid is lowered only in the idle loop here and in settle, so back-to-back samples keep it high
  task automatic send_tilt(tpid_pkg::sample_t roll, tpid_pkg::sample_t pitch,
                           tpid_pkg::sample_t yaw);
    while ($urandom_range(99) < src_idle_pct) begin
      tilt_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    tilt_ch.valid      <= 1'b1;
    tilt_ch.tilt_roll  <= roll;
    tilt_ch.tilt_pitch <= pitch;
    tilt_ch.tilt_yaw   <= yaw;
    do @(posedge clk_i); while (!tilt_ch.ready);
    board.note_tilt(roll, pitch, yaw);
  endtask

  task automatic cfg_write(logic [tpid_pkg::CfgIdxW-1:0] idx,
                           logic [tpid_pkg::CfgDataW-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    board.write_reg(idx, data);
  endtask

  task automatic cfg_release();
    cfg_ch.valid <= 1'b0;
  endtask

  // stop sending and let the unit go quiet before touching registers
  task automatic settle();
    tilt_ch.valid <= 1'b0;
    while (board.pending() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [tpid_pkg::CfgDataW-1:0] pick_gain();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3, 4, 5: return tpid_pkg::CfgDataW'($urandom_range(1024) - 512);
      default: return tpid_pkg::CfgDataW'($urandom);
    endcase
  endfunction

  function automatic logic [tpid_pkg::CfgDataW-1:0] pick_filt();
    case ($urandom_range(4))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return tpid_pkg::CfgDataW'($urandom);
    endcase
  endfunction

  // upper bits are random, only the low seven reach the register
  function automatic logic [tpid_pkg::CfgDataW-1:0] pick_win_len();
    logic [tpid_pkg::LenW-1:0] len;
    case ($urandom_range(7))
      0:       len = '0;
      1:       len = tpid_pkg::LenW'(1);
      2:       len = tpid_pkg::LenW'(tpid_pkg::MaxWindow);
      3:       len = tpid_pkg::LenW'($urandom_range(2**tpid_pkg::LenW - 1,
                                                    tpid_pkg::MaxWindow + 1));
      default: len = tpid_pkg::LenW'($urandom_range(tpid_pkg::MaxWindow - 1, 2));
    endcase
    return (tpid_pkg::CfgDataW'($urandom) & ~tpid_pkg::CfgDataW'(2**tpid_pkg::LenW - 1))
         | tpid_pkg::CfgDataW'(len);
  endfunction

  task automatic apply_random_settings();
    cfg_write(tpid_pkg::CFG_GAIN_PROP, pick_gain());
    cfg_write(tpid_pkg::CFG_GAIN_INTEG, pick_gain());
    cfg_write(tpid_pkg::CFG_GAIN_DERIV, pick_gain());
    cfg_write(tpid_pkg::CFG_FILT, pick_filt());
    cfg_write(tpid_pkg::CFG_WIN_LEN, pick_win_len());
    if ($urandom_range(99) < 30)
      cfg_write(tpid_pkg::CfgIdxW'($urandom_range(2**tpid_pkg::CfgIdxW - 1,
                                                  tpid_pkg::CFG_WIN_LEN + 1)),
                tpid_pkg::CfgDataW'($urandom));
    cfg_release();
  endtask

  function automatic tpid_pkg::sample_t pick_sample();
    int sel;
    sel = $urandom_range(99);
    if (sel < 45) return tpid_pkg::sample_t'($urandom);
    if (sel < 80) return tpid_pkg::sample_t'($urandom_range(1024) - 512);
    case ($urandom_range(3))
      0:       return SampleMax;
      1:       return SampleMin;
      2:       return '0;
      default: return -1;
    endcase
  endfunction

  // repeated samples let the window sum build up and the derivative settle
  task automatic run_block(int count);
    tpid_pkg::sample_t roll, pitch, yaw;
    roll  = '0;
    pitch = '0;
    yaw   = '0;
    for (int i = 0; i < count; i++) begin
      if (i == 0 || $urandom_range(99) >= 20) begin
        roll  = pick_sample();
        pitch = pick_sample();
        yaw   = pick_sample();
      end
      send_tilt(roll, pitch, yaw);
    end
  endtask

  initial begin
    rst_ni             <= 1'b0;
    tilt_ch.valid      <= 1'b0;
    tilt_ch.tilt_roll  <= '0;
    tilt_ch.tilt_pitch <= '0;
    tilt_ch.tilt_yaw   <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= '0;
    cfg_ch.data        <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings
    send_tilt('0, '0, '0);
    send_tilt(SampleMax, SampleMin, 16'sd1);
    send_tilt(SampleMin, SampleMax, -16'sd1);
    send_tilt(SampleMax, SampleMax, SampleMax);
    settle();

    // extreme gains, filter factor zero freezes the derivative, window length zero acts as one sample
    cfg_write(tpid_pkg::CFG_GAIN_PROP, 16'h7FFF);
    cfg_write(tpid_pkg::CFG_GAIN_INTEG, 16'h8000);
    cfg_write(tpid_pkg::CFG_GAIN_DERIV, 16'h7FFF);
    cfg_write(tpid_pkg::CFG_FILT, 16'h0000);
    cfg_write(tpid_pkg::CFG_WIN_LEN, 16'h0000);
    cfg_release();
    send_tilt(SampleMax, SampleMin, SampleMax);
    send_tilt(SampleMin, SampleMax, SampleMin);
    send_tilt(SampleMin, SampleMin, '0);
    send_tilt('0, SampleMax, 16'sd1);
    settle();

    // length past the maximum clamps to it; unused index must change nothing
    cfg_write(tpid_pkg::CFG_GAIN_PROP, 16'h8000);
    cfg_write(tpid_pkg::CFG_GAIN_INTEG, 16'h7FFF);
    cfg_write(tpid_pkg::CFG_GAIN_DERIV, 16'h8000);
    cfg_write(tpid_pkg::CFG_FILT, 16'hFFFF);
    cfg_write(tpid_pkg::CFG_WIN_LEN, 16'hFF7F);
    cfg_write(tpid_pkg::CfgIdxW'(tpid_pkg::CFG_WIN_LEN + 1), 16'h0001);
    cfg_write(tpid_pkg::CfgIdxW'(2**tpid_pkg::CfgIdxW - 1), 16'hFFFF);
    cfg_release();
    send_tilt(SampleMin, SampleMax, SampleMin);
    send_tilt(SampleMax, SampleMin, SampleMax);
    send_tilt(-16'sd1, 16'sd1, '0);
    send_tilt(SampleMax, SampleMax, SampleMax);
    send_tilt(SampleMin, SampleMin, SampleMin);
    settle();

    // full window, mid filter factor, sum driven by extreme samples
    cfg_write(tpid_pkg::CFG_GAIN_PROP, 16'h0100);
    cfg_write(tpid_pkg::CFG_GAIN_INTEG, 16'h0040);
    cfg_write(tpid_pkg::CFG_FILT, 16'h8000);
    cfg_write(tpid_pkg::CFG_WIN_LEN, tpid_pkg::CfgDataW'(tpid_pkg::MaxWindow));
    cfg_release();
    for (int i = 0; i < 3; i++) send_tilt(SampleMin, SampleMin, SampleMin);
    for (int i = 0; i < 3; i++) send_tilt(SampleMax, SampleMax, SampleMax);

    // no idling, sender idle, receiver stalling, both
    for (int phase = 0; phase < 4; phase++) begin
      for (int blk = 0; blk < 3; blk++) begin
        settle();
        apply_random_settings();
        case (phase)
          0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
          1: begin src_idle_pct = 60; snk_stall_pct = 0;  end
          2: begin src_idle_pct = 0;  snk_stall_pct = 60; end
          default: begin src_idle_pct = 16; snk_stall_pct = 16; end
        endcase
        run_block(75);
      end
    end

    settle();
    if (board.errors == 0 && board.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
